// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W = 64;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic enq;        // insert the new item this cycle
        logic deq;        // pop the front this cycle
        logic valid;      // cell holds a stored entry
        logic left_disp;  // left neighbor is displaced by the new item
    } t_cell_ctl;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              i_clk,
    input  spq_pkg::t_cell_ctl                i_ctl,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_new_prio,
    input  logic [spq_pkg::VALUE_W-1:0]       i_new_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_left_prio,
    input  logic [spq_pkg::VALUE_W-1:0]       i_left_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_right_prio,
    input  logic [spq_pkg::VALUE_W-1:0]       i_right_value,
    output logic                              o_disp,
    output logic signed [spq_pkg::PRIO_W-1:0] o_prio,
    output logic [spq_pkg::VALUE_W-1:0]       o_value
);

    logic signed [spq_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic [spq_pkg::VALUE_W-1:0]       r_value, n_value;

    // strict compare keeps equal priorities in arrival order
    assign o_disp = !i_ctl.valid || (r_prio > i_new_prio);

    always_comb begin
        n_prio  = r_prio;
        n_value = r_value;
        if (i_ctl.deq) begin
            n_prio  = i_right_prio;
            n_value = i_right_value;
        end else if (i_ctl.enq && o_disp) begin
            if (i_ctl.left_disp) begin
                n_prio  = i_left_prio;
                n_value = i_left_value;
            end else begin
                n_prio  = i_new_prio;
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio  <= n_prio;
        r_value <= n_value;
    end

    assign o_prio  = r_prio;
    assign o_value = r_value;

endmodule

// ----- rtl/stable_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Sorted priority queue built as a row of QUEUE_DEPTH cells with parallel compares.
// The result strobe o_done is registered and rises in the cycle after start is accepted.
// Throughput: one item per cycle; busy stays low, and every cell shifts or inserts on the same edge.
// Results cannot be stalled: each one is shown for a single cycle on o_done.
// Synchronous active-low reset empties the queue and clears the strobe.
module stable_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_operation,
    input  logic [spq_pkg::VALUE_W-1:0]       i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0] i_item_priority,
    output logic                              o_done,
    output logic [spq_pkg::VALUE_W-1:0]       o_removed_value,
    output logic [spq_pkg::VALUE_W-1:0]       o_front_value,
    output logic [spq_pkg::COUNT_W-1:0]       o_entry_count,
    output logic [spq_pkg::STAT_W-1:0]        o_status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = (CW > spq_pkg::COUNT_W) ? CW : spq_pkg::COUNT_W;

    logic [CW-1:0]                r_count, n_count;
    logic                         r_done;
    logic [spq_pkg::VALUE_W-1:0]  r_removed;
    logic [spq_pkg::STAT_W-1:0]   r_status;

    logic                         accept, full, empty, enq_ok, deq_ok;
    logic [EW-1:0]                count_ext;

    logic                              disp   [QUEUE_DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] c_prio [QUEUE_DEPTH];
    logic [spq_pkg::VALUE_W-1:0]       c_value[QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CW'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);
    assign enq_ok = accept && (i_operation == spq_pkg::OP_ENQUEUE) && !full;
    assign deq_ok = accept && (i_operation == spq_pkg::OP_DEQUEUE) && !empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_pkg::t_cell_ctl                ctl;
        logic signed [spq_pkg::PRIO_W-1:0] left_prio, right_prio;
        logic [spq_pkg::VALUE_W-1:0]       left_value, right_value;

        assign ctl.enq   = enq_ok;
        assign ctl.deq   = deq_ok;
        assign ctl.valid = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign ctl.left_disp = 1'b0;
            assign left_prio     = i_item_priority;
            assign left_value    = i_item_value;
        end else begin : g_mid
            assign ctl.left_disp = disp[g-1];
            assign left_prio     = c_prio[g-1];
            assign left_value    = c_value[g-1];
        end

        // the last cell keeps its contents on a pop; it falls outside the count
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_prio  = c_prio[g];
            assign right_value = c_value[g];
        end else begin : g_inner
            assign right_prio  = c_prio[g+1];
            assign right_value = c_value[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_new_prio   (i_item_priority),
            .i_new_value  (i_item_value),
            .i_left_prio  (left_prio),
            .i_left_value (left_value),
            .i_right_prio (right_prio),
            .i_right_value(right_value),
            .o_disp       (disp[g]),
            .o_prio       (c_prio[g]),
            .o_value      (c_value[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (enq_ok) begin
            n_count = r_count + 1'b1;
        end else if (deq_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= deq_ok ? c_value[0] : '0;
            if (i_operation == spq_pkg::OP_DEQUEUE) begin
                r_status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
            end else begin
                r_status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end
        end
    end

    assign count_ext       = EW'(r_count);
    assign o_done          = r_done;
    assign o_removed_value = r_removed;
    assign o_front_value   = (r_count != '0) ? c_value[0] : '0;
    assign o_entry_count   = count_ext[spq_pkg::COUNT_W-1:0];
    assign o_status        = r_status;

endmodule

// ----- rtl/spq_checker.sv -----
`timescale 1ns / 1ps

module spq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              i_operation,
    input logic [spq_pkg::VALUE_W-1:0]       i_item_value,
    input logic signed [spq_pkg::PRIO_W-1:0] i_item_priority,
    input logic                              o_done,
    input logic [spq_pkg::VALUE_W-1:0]       o_removed_value,
    input logic [spq_pkg::VALUE_W-1:0]       o_front_value,
    input logic [spq_pkg::COUNT_W-1:0]       o_entry_count,
    input logic [spq_pkg::STAT_W-1:0]        o_status
);

    // every accepted item gives exactly one result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted item without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without accepted item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

    a_fail_no_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != spq_pkg::ST_OK) |-> (o_removed_value == '0))
        else $error("failed request reports a removed item");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == spq_pkg::ST_EMPTY) |->
            (o_entry_count == '0 && o_front_value == '0))
        else $error("empty dequeue with stored entries");

endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (.*);

// ----- tb/stable_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1750;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [spq_pkg::VALUE_W-1:0] removed;
        logic [spq_pkg::VALUE_W-1:0] front;
        logic [spq_pkg::COUNT_W-1:0] count;
        logic [spq_pkg::STAT_W-1:0]  status;
    } t_queue_result;

    typedef struct {
        logic                              op;
        logic [spq_pkg::VALUE_W-1:0]       value;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        bit                                typed;
        t_queue_result                     want;
    } t_dir_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              i_operation = spq_pkg::OP_ENQUEUE;
    logic [spq_pkg::VALUE_W-1:0]       i_item_value = '0;
    logic signed [spq_pkg::PRIO_W-1:0] i_item_priority = '0;
    logic                              o_done;
    logic [spq_pkg::VALUE_W-1:0]       o_removed_value;
    logic [spq_pkg::VALUE_W-1:0]       o_front_value;
    logic [spq_pkg::COUNT_W-1:0]       o_entry_count;
    logic [spq_pkg::STAT_W-1:0]        o_status;

    // typed expectation travels with the item it belongs to
    bit                                item_typed = 1'b0;
    t_queue_result                     item_want = '0;

    // shadow copy of the sorted queue
    logic [spq_pkg::VALUE_W-1:0]       q_payload [QDEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] q_prio [QDEPTH];
    int                                q_count = 0;

    t_queue_result              pending_results [$];
    t_dir_row                   dir_rows [$];

    int cycle_cnt    = 0;
    int mismatches   = 0;
    int checked      = 0;
    int n_items      = 0;
    int n_enq        = 0;
    int n_deq        = 0;
    int n_full_drop  = 0;
    int n_empty_flag = 0;
    int peak_count   = 0;

    stable_priority_queue_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_done          (o_done),
        .o_removed_value (o_removed_value),
        .o_front_value   (o_front_value),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_queue_result apply_request(
            input logic op,
            input logic [spq_pkg::VALUE_W-1:0] value,
            input logic signed [spq_pkg::PRIO_W-1:0] prio);
        t_queue_result r;
        int pos;
        r = '0;
        r.status = spq_pkg::ST_OK;
        if (op == spq_pkg::OP_DEQUEUE) begin
            if (q_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.removed = q_payload[0];
                for (int k = 1; k < q_count; k++) begin
                    q_payload[k-1] = q_payload[k];
                    q_prio[k-1]    = q_prio[k];
                end
                q_count--;
            end
        end else begin
            if (q_count >= QDEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                // new entry goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < q_count && q_prio[pos] <= prio)
                    pos++;
                for (int k = q_count; k > pos; k--) begin
                    q_payload[k] = q_payload[k-1];
                    q_prio[k]    = q_prio[k-1];
                end
                q_payload[pos] = value;
                q_prio[pos]    = prio;
                q_count++;
            end
        end
        r.front = (q_count > 0) ? q_payload[0] : '0;
        r.count = q_count[spq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // result check, then bookkeeping of the item accepted at this edge
    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        t_queue_result predicted;
        if (i_rst_n && o_done) begin
            got = '{o_removed_value, o_front_value, o_entry_count, o_status};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: removed %h front %h count %0d status %0d",
                             got.removed, got.front, got.count, got.status);
            end else begin
                want = pending_results.pop_front();
                checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on result %0d:", checked);
                        $display("  exp removed %h front %h count %0d status %0d",
                                 want.removed, want.front, want.count, want.status);
                        $display("  got removed %h front %h count %0d status %0d",
                                 got.removed, got.front, got.count, got.status);
                    end
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            predicted = apply_request(i_operation, i_item_value, i_item_priority);
            pending_results.push_back(item_typed ? item_want : predicted);
            n_items++;
            if (i_operation == spq_pkg::OP_DEQUEUE) n_deq++;
            else n_enq++;
            if (predicted.status == spq_pkg::ST_FULL) n_full_drop++;
            if (predicted.status == spq_pkg::ST_EMPTY) n_empty_flag++;
            if (q_count > peak_count) peak_count = q_count;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic drive_request(input logic op, input logic [spq_pkg::VALUE_W-1:0] value,
                                 input logic signed [spq_pkg::PRIO_W-1:0] prio,
                                 input bit typed, input t_queue_result want,
                                 input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        item_typed      <= typed;
        item_want       <= want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic add_row(input logic op, input logic [spq_pkg::VALUE_W-1:0] value,
                           input logic signed [spq_pkg::PRIO_W-1:0] prio, input bit typed,
                           input t_queue_result want);
        t_dir_row row;
        row.op    = op;
        row.value = value;
        row.prio  = prio;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // start drops and the last accepted item is booked before the wait for results
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_prio(input int mode);
        logic signed [spq_pkg::PRIO_W-1:0] p;
        case (mode)
            0: p = spq_pkg::PRIO_W'($urandom_range(65535));
            1: p = spq_pkg::PRIO_W'($urandom_range(6)) - 16'sd3;   // heavy ties
            default: begin
                case ($urandom_range(3))
                    0: p = 16'sh8000;
                    1: p = 16'sh7FFF;
                    2: p = 16'sh0000;
                    default: p = 16'shFFFF;
                endcase
            end
        endcase
        return p;
    endfunction

    initial begin
        t_queue_result none;
        int enq_pct;
        int prio_mode;
        int idle_pct;
        int drain_wait;
        logic op;

        none = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, extremes, ties, fill to full, overflow, partial drain
        add_row(spq_pkg::OP_DEQUEUE, '1, -16'sd1, 1'b1,
                '{'0, '0, 5'd0, spq_pkg::ST_EMPTY});
        add_row(spq_pkg::OP_ENQUEUE, '1, 16'sh7FFF, 1'b1, '{'0, '1, 5'd1, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_ENQUEUE, '0, 16'sh8000, 1'b1, '{'0, '0, 5'd2, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_ENQUEUE, 64'h0123_4567_89AB_CDEF, 16'sd0, 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'hFEDC_BA98_7654_3210, 16'sd0, 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'h5555_5555_5555_5555, 16'sh8000, 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'hAAAA_AAAA_AAAA_AAAA, 16'sh7FFF, 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'h8000_0000_0000_0001, -16'sd1, 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'h7FFF_FFFF_FFFF_FFFE, 16'sd1, 1'b0, none);
        for (int i = 0; i < 8; i++)
            add_row(spq_pkg::OP_ENQUEUE, 64'h1111_1111_1111_1111 * (i + 1),
                    spq_pkg::PRIO_W'((i % 3) - 1), 1'b0, none);
        // queue is full: the extreme-low zero payload still sits in front
        add_row(spq_pkg::OP_ENQUEUE, 64'hDEAD_BEEF_0000_0001, 16'sh8000, 1'b1,
                '{'0, '0, 5'd16, spq_pkg::ST_FULL});
        for (int i = 0; i < 6; i++)
            add_row(spq_pkg::OP_DEQUEUE, {$urandom, $urandom},
                    spq_pkg::PRIO_W'($urandom), 1'b0, none);
        add_row(spq_pkg::OP_ENQUEUE, 64'h0000_0000_FFFF_FFFF, 16'sh8000, 1'b0, none);

        foreach (dir_rows[i])
            drive_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].prio,
                          dir_rows[i].typed, dir_rows[i].want, 0);

        // random part in three phases of sender idling, with a full pause between
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 50 : 0;
            enq_pct = 50;
            prio_mode = 0;
            for (int n = 0; n < RAND_ITEMS / 3; n++) begin
                // bias shifts so the queue swings between full and empty
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: enq_pct = 85;
                        1: enq_pct = 50;
                        default: enq_pct = 15;
                    endcase
                    prio_mode = $urandom_range(2);
                end
                op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                     : spq_pkg::OP_DEQUEUE;
                drive_request(op, {$urandom, $urandom}, pick_prio(prio_mode), 1'b0,
                              none, idle_pct);
            end
        end

        start <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < 100) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("%0d items: %0d enqueue, %0d dequeue; %0d dropped when full, %0d on empty",
                 n_items, n_enq, n_deq, n_full_drop, n_empty_flag);
        $display("peak depth %0d of %0d, %0d results checked, %0d mismatches",
                 peak_count, QDEPTH, checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- stable_priority_queue_core.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_core.sv
rtl/spq_checker.sv
tb/stable_priority_queue_core_tb.sv
